/* hdl/kvhex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhex_pkg
// Shared types, constants and helpers of the key/value hex field extractor.
// ----------------------------------------------------------------------------
package kvhex_pkg;

    localparam int KEY_CHARS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int KEY_TEXT_W  = 64;
    localparam int KEY_LEN_W   = 4;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NO_KEY    = 3'd1;
    localparam logic [2:0] STATUS_EMPTY     = 3'd2;
    localparam logic [2:0] STATUS_ODD       = 3'd3;
    localparam logic [2:0] STATUS_BAD_DIGIT = 3'd4;

    localparam logic REG_KEY_TEXT   = 1'b0;
    localparam logic REG_KEY_LENGTH = 1'b1;

    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status_code;
    } out_t;

    // One entry of the queue between front and back
    typedef struct packed {
        logic       is_end;
        logic       found;
        logic       digit_ok;
        logic [3:0] nibble;
    } token_t;

    typedef struct packed {
        logic ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            h.value = 4'(c - CH_ZERO);
        end
        else if (c >= CH_LOW_A && c <= CH_LOW_F)
        begin
            h.value = 4'(c - CH_LOW_A) + 4'd10;
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            h.value = 4'(c - CH_UP_A) + 4'd10;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* hdl/kvhex_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhex_front
// Accepts characters, searches the sliding window for key plus '=', and
// queues value characters (decoded to nibbles) and end-of-line markers.
// ----------------------------------------------------------------------------
module kvhex_front #(
    parameter int KEY_CHARS = kvhex_pkg::KEY_CHARS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  kvhex_pkg::in_t                    in_data,
    input  logic [8*KEY_CHARS-1:0]            key_text,
    input  logic [kvhex_pkg::KEY_LEN_W-1:0]   key_length,
    input  logic                              queue_full,
    output logic                              push,
    output kvhex_pkg::token_t                 push_data
);

    localparam int WIN_W  = 8 * KEY_CHARS;
    localparam int SEEN_W = $clog2(KEY_CHARS + 1);

    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_VALUE  = 2'd1;
    localparam logic [1:0] MODE_DONE   = 2'd2;

    logic [1:0]        mode_reg,  mode_next;
    logic [WIN_W-1:0]  window_reg, window_next;
    logic [SEEN_W-1:0] seen_reg,  seen_next;

    logic                            accept;
    logic [kvhex_pkg::KEY_LEN_W-1:0] klen;
    logic [KEY_CHARS-1:0]            byte_ok;
    logic                            key_hit;
    kvhex_pkg::hex_t                 hex;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign klen = (key_length > kvhex_pkg::KEY_LEN_W'(KEY_CHARS))
                  ? kvhex_pkg::KEY_LEN_W'(KEY_CHARS) : key_length;

    always_comb
    begin
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            byte_ok[i] = (kvhex_pkg::KEY_LEN_W'(i) >= klen)
                         || (window_reg[8*i +: 8] == key_text[8*i +: 8]);
        end
    end

    assign key_hit = (in_data.char_in == kvhex_pkg::CH_EQUALS)
                     && (kvhex_pkg::KEY_LEN_W'(seen_reg) >= klen)
                     && (&byte_ok);

    assign hex = kvhex_pkg::hex_decode(in_data.char_in);

    always_comb
    begin
        mode_next          = mode_reg;
        window_next        = window_reg;
        seen_next          = seen_reg;
        push               = 1'b0;
        push_data.is_end   = in_data.line_end;
        push_data.found    = (mode_reg != MODE_SEARCH);
        push_data.digit_ok = hex.ok;
        push_data.nibble   = hex.value;
        if (accept)
        begin
            if (in_data.line_end)
            begin
                push        = 1'b1;
                mode_next   = MODE_SEARCH;
                window_next = '0;
                seen_next   = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_SEARCH:
                    begin
                        if (key_hit)
                        begin
                            mode_next = MODE_VALUE;
                        end
                        else
                        begin
                            window_next = WIN_W'({window_reg, in_data.char_in});
                            if (seen_reg != SEEN_W'(KEY_CHARS))
                            begin
                                seen_next = seen_reg + SEEN_W'(1);
                            end
                        end
                    end
                    MODE_VALUE:
                    begin
                        if (in_data.char_in == kvhex_pkg::CH_SEMI)
                        begin
                            mode_next = MODE_DONE;
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SEARCH;
            window_reg <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

/* hdl/kvhex_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhex_queue
// Short register FIFO of tokens between the front and back ends.
// ----------------------------------------------------------------------------
module kvhex_queue #(
    parameter int DEPTH = kvhex_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kvhex_pkg::token_t push_data,
    output logic              full,
    input  logic              pop,
    output kvhex_pkg::token_t pop_data,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kvhex_pkg::token_t slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

/* hdl/kvhex_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhex_back
// Pairs value nibbles into bytes, tracks value errors and emits the line
// status; results go through an output register.
// ----------------------------------------------------------------------------
module kvhex_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  kvhex_pkg::token_t queue_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output kvhex_pkg::out_t   out_data
);

    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       half_pair_reg,   half_pair_next;
    logic       nonempty_reg,    nonempty_next;
    logic       digit_error_reg, digit_error_next;
    logic       out_valid_reg,   out_valid_next;
    kvhex_pkg::out_t out_data_reg, out_data_next;

    logic emit;
    logic err_now;
    kvhex_pkg::out_t result;

    assign pop     = !queue_empty && (!out_valid_reg || out_ready);
    assign err_now = digit_error_reg || !queue_data.digit_ok;

    always_comb
    begin
        high_nibble_next   = high_nibble_reg;
        half_pair_next     = half_pair_reg;
        nonempty_next      = nonempty_reg;
        digit_error_next   = digit_error_reg;
        emit               = 1'b0;
        result.out_byte    = {high_nibble_reg, queue_data.nibble};
        result.is_status   = 1'b0;
        result.status_code = kvhex_pkg::STATUS_OK;
        if (pop)
        begin
            if (queue_data.is_end)
            begin
                emit             = 1'b1;
                result.out_byte  = '0;
                result.is_status = 1'b1;
                if (!queue_data.found)
                begin
                    result.status_code = kvhex_pkg::STATUS_NO_KEY;
                end
                else if (!nonempty_reg)
                begin
                    result.status_code = kvhex_pkg::STATUS_EMPTY;
                end
                else if (half_pair_reg)
                begin
                    result.status_code = kvhex_pkg::STATUS_ODD;
                end
                else if (digit_error_reg)
                begin
                    result.status_code = kvhex_pkg::STATUS_BAD_DIGIT;
                end
                high_nibble_next = '0;
                half_pair_next   = 1'b0;
                nonempty_next    = 1'b0;
                digit_error_next = 1'b0;
            end
            else
            begin
                nonempty_next    = 1'b1;
                digit_error_next = err_now;
                if (!half_pair_reg)
                begin
                    half_pair_next = 1'b1;
                    if (!err_now)
                    begin
                        high_nibble_next = queue_data.nibble;
                    end
                end
                else
                begin
                    half_pair_next = 1'b0;
                    emit           = !err_now;
                end
            end
        end
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (emit)
        begin
            out_data_next  = result;
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_nibble_reg <= '0;
            half_pair_reg   <= 1'b0;
            nonempty_reg    <= 1'b0;
            digit_error_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            high_nibble_reg <= high_nibble_next;
            half_pair_reg   <= half_pair_next;
            nonempty_reg    <= nonempty_next;
            digit_error_reg <= digit_error_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    a_half_needs_value: assert property (@(posedge clk) disable iff (!rst_n)
        half_pair_reg |-> nonempty_reg)
        else $error("half pair without value character");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && queue_data.is_end) |=> (!half_pair_reg && !nonempty_reg && !digit_error_reg))
        else $error("line state not cleared at end of line");

    a_status_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.is_status) |-> (out_data_reg.status_code == kvhex_pkg::STATUS_OK))
        else $error("data byte carries a status code");

endmodule

/* hdl/key_value_hex_field_extractor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_hex_field_extractor
// Finds key= in a character line and decodes the value as hex byte pairs,
// then reports one status per line.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_data  (char_in, line_end)
//   out      output     out_valid/out_ready  out_data (out_byte, is_status,
//                                                      status_code)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One character per cycle while in_ready is high; the token is written into the
// queue at its transfer, and the back end pops it once the output register is
// empty or being read, loading any result into that register.
// Front and back are parted by a QUEUE_DEPTH-entry token queue; in_ready drops
// only when the queue is full, which happens when out_ready is held low.
// Reset clears line state, key registers and queue; no clearing pass.
// ----------------------------------------------------------------------------
module key_value_hex_field_extractor #(
    parameter int KEY_CHARS   = kvhex_pkg::KEY_CHARS,
    parameter int QUEUE_DEPTH = kvhex_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  kvhex_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output kvhex_pkg::out_t                     out_data,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [kvhex_pkg::KEY_TEXT_W-1:0]    cfg_data
);

    logic [kvhex_pkg::KEY_TEXT_W-1:0] key_text_reg;
    logic [kvhex_pkg::KEY_LEN_W-1:0]  key_length_reg;

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    kvhex_pkg::token_t push_data;
    kvhex_pkg::token_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_text_reg   <= '0;
            key_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kvhex_pkg::REG_KEY_TEXT:
                begin
                    key_text_reg <= cfg_data;
                end
                kvhex_pkg::REG_KEY_LENGTH:
                begin
                    key_length_reg <= cfg_data[kvhex_pkg::KEY_LEN_W-1:0];
                end
                default:
                begin
                    key_text_reg <= key_text_reg;
                end
            endcase
        end
    end

    kvhex_front #(
        .KEY_CHARS (KEY_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .key_text   (key_text_reg[8*KEY_CHARS-1:0]),
        .key_length (key_length_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    kvhex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    kvhex_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

/* dv/key_value_hex_field_extractor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_hex_field_extractor_tb
// Drives character lines, each closed by a line end, through several key
// settings. A scoreboard predicts the decoded bytes and the status of every
// line. Each output transfer is checked in order against that prediction.
// Both handshakes idle at random.
// ----------------------------------------------------------------------------
module key_value_hex_field_extractor_tb;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 115;
    localparam int MAX_SHOWN   = 100;

    localparam logic [1:0] SEEK_KEY     = 2'd0;
    localparam logic [1:0] IN_VALUE     = 2'd1;
    localparam logic [1:0] VALUE_CLOSED = 2'd2;

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= kvhex_pkg::CH_ZERO && c <= kvhex_pkg::CH_NINE) ||
               (c >= kvhex_pkg::CH_LOW_A && c <= kvhex_pkg::CH_LOW_F) ||
               (c >= kvhex_pkg::CH_UP_A && c <= kvhex_pkg::CH_UP_F);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= kvhex_pkg::CH_NINE)
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    function automatic int key_span(input logic [3:0] len);
        return (len > kvhex_pkg::KEY_CHARS) ? kvhex_pkg::KEY_CHARS : int'(len);
    endfunction

    class kv_line_checker;
        logic [63:0]     key_text;
        logic [3:0]      key_length;
        logic [1:0]      scan;
        logic [63:0]     recent;
        int unsigned     seen;
        logic [3:0]      hi_nibble;
        bit              half_pair;
        bit              has_value;
        bit              bad_digit;
        kvhex_pkg::out_t decoded_q[$];
        int              mismatch_count;
        int              byte_count;
        int              status_tally[5];

        function new();
            key_text       = '0;
            key_length     = '0;
            mismatch_count = 0;
            byte_count     = 0;
            foreach (status_tally[i])
            begin
                status_tally[i] = 0;
            end
            clear_line();
        endfunction

        function void clear_line();
            scan      = SEEK_KEY;
            recent    = '0;
            seen      = 0;
            hi_nibble = '0;
            half_pair = 1'b0;
            has_value = 1'b0;
            bad_digit = 1'b0;
        endfunction

        function void set_reg(input logic idx, input logic [63:0] data);
            if (idx == kvhex_pkg::REG_KEY_TEXT)
            begin
                key_text = data;
            end
            else
            begin
                key_length = data[3:0];
            end
        endfunction

        function void note_transfer(input kvhex_pkg::in_t t);
            kvhex_pkg::out_t r;
            int              klen;
            logic [63:0]     mask;
            logic [3:0]      nib;
            r = '0;
            if (t.line_end)
            begin
                r.is_status = 1'b1;
                if (scan == SEEK_KEY)
                    r.status_code = kvhex_pkg::STATUS_NO_KEY;
                else if (!has_value)
                    r.status_code = kvhex_pkg::STATUS_EMPTY;
                else if (half_pair)
                    r.status_code = kvhex_pkg::STATUS_ODD;
                else if (bad_digit)
                    r.status_code = kvhex_pkg::STATUS_BAD_DIGIT;
                else
                    r.status_code = kvhex_pkg::STATUS_OK;
                decoded_q.insert(decoded_q.size(), r);
                clear_line();
                return;
            end
            case (scan)
                SEEK_KEY:
                begin
                    klen = key_span(key_length);
                    mask = (klen == 0) ? 64'd0 : ({64{1'b1}} >> (64 - 8 * klen));
                    if (t.char_in == kvhex_pkg::CH_EQUALS && seen >= klen &&
                        (recent & mask) == (key_text & mask))
                    begin
                        scan = IN_VALUE;
                    end
                    else
                    begin
                        recent = {recent[55:0], t.char_in};
                        if (seen < kvhex_pkg::KEY_CHARS)
                            seen++;
                    end
                end
                IN_VALUE:
                begin
                    if (t.char_in == kvhex_pkg::CH_SEMI)
                    begin
                        scan = VALUE_CLOSED;
                    end
                    else
                    begin
                        has_value = 1'b1;
                        nib = nibble_of(t.char_in);
                        if (!is_hex(t.char_in))
                            bad_digit = 1'b1;
                        if (!half_pair)
                        begin
                            half_pair = 1'b1;
                            if (!bad_digit)
                                hi_nibble = nib;
                        end
                        else
                        begin
                            half_pair = 1'b0;
                            if (!bad_digit)
                            begin
                                r.out_byte = {hi_nibble, nib};
                                decoded_q.insert(decoded_q.size(), r);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(input string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
                $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(input kvhex_pkg::out_t got);
            kvhex_pkg::out_t want;
            if (decoded_q.size() == 0)
            begin
                report($sformatf("unexpected transfer byte=%02h is_status=%0b code=%0d",
                                 got.out_byte, got.is_status, got.status_code));
                return;
            end
            want = decoded_q.pop_front();
            if (got.is_status !== want.is_status)
                report($sformatf("is_status %0b, want %0b", got.is_status, want.is_status));
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.status_code !== want.status_code)
                report($sformatf("status_code %0d, want %0d",
                                 got.status_code, want.status_code));
            if (want.is_status)
                status_tally[want.status_code]++;
            else
                byte_count++;
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    kvhex_pkg::in_t  in_data;
    logic            out_valid;
    logic            out_ready;
    kvhex_pkg::out_t out_data;
    logic            cfg_we;
    logic            cfg_index;
    logic [63:0]     cfg_data;

    kv_line_checker model;
    logic [7:0]     line_buf[$];
    int             items_sent;
    int             lines_sent;

    key_value_hex_field_extractor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            model.check_result(out_data);
    end

    function automatic void add_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10)
            return kvhex_pkg::CH_ZERO + 8'(n);
        if ($urandom_range(0, 1))
            return kvhex_pkg::CH_LOW_A + 8'(n - 10);
        return kvhex_pkg::CH_UP_A + 8'(n - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (is_hex(c) || c == kvhex_pkg::CH_SEMI);
        return c;
    endfunction

    function automatic logic [7:0] key_char(input int i);
        int klen;
        klen = key_span(model.key_length);
        return model.key_text[8 * (klen - 1 - i) +: 8];
    endfunction

    function automatic logic [7:0] mixed_char(input bit allow_eq);
        int r;
        r = $urandom_range(0, 9);
        if (r <= 2)
            return hex_char();
        if (r <= 4 && key_span(model.key_length) > 0)
            return key_char($urandom_range(0, key_span(model.key_length) - 1));
        if (r == 5 && allow_eq)
            return kvhex_pkg::CH_EQUALS;
        if (r == 6)
            return kvhex_pkg::CH_SEMI;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] printable_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++)
        begin
            k[8 * i +: 8] = 8'($urandom_range(8'h21, 8'h7E));
        end
        return k;
    endfunction

    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(input kvhex_pkg::in_t item);
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = item;
        do @(posedge clk); while (!in_ready);
        model.note_transfer(item);
        items_sent++;
    endtask

    task automatic send_line(input bit quiet);
        kvhex_pkg::in_t item;
        foreach (line_buf[i])
        begin
            item.char_in  = line_buf[i];
            item.line_end = 1'b0;
            send_item(item);
            if (!quiet)
                idle_input(pick_gap());
        end
        item.char_in  = 8'($urandom_range(0, 255));
        item.line_end = 1'b1;
        send_item(item);
        if (!quiet)
            idle_input(pick_gap());
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        foreach (s[i])
        begin
            add_char(s[i]);
        end
        send_line(1'($urandom_range(0, 1)));
    endtask

    task automatic compose_line();
        int kind;
        int klen;
        int n;
        int pairs;
        int flaw;
        int pos;
        bit damaged;
        bit drop_eq;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        klen = key_span(model.key_length);
        if (kind < 75)
        begin
            damaged = (kind >= 60);
            drop_eq = damaged && (klen == 0 || $urandom_range(0, 1));
            n = $urandom_range(0, 4);
            repeat (n) add_char(mixed_char(1'b0));
            for (int i = 0; i < klen; i++)
            begin
                add_char(key_char(i));
            end
            if (damaged && !drop_eq)
            begin
                pos = line_buf.size() - 1 - $urandom_range(0, klen - 1);
                line_buf[pos] = line_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            if (!drop_eq)
                add_char(kvhex_pkg::CH_EQUALS);
            pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
            repeat (2 * pairs) add_char(hex_char());
            flaw = $urandom_range(0, 9);
            if ((flaw == 0 || flaw == 2) && pairs > 0)
                void'(line_buf.pop_back());
            if ((flaw == 1 || flaw == 2) && pairs > 0)
            begin
                pos = line_buf.size() - 1 - $urandom_range(0, 2 * pairs - 2);
                line_buf[pos] = non_hex_char();
            end
            if ($urandom_range(0, 3) == 0)
            begin
                add_char(kvhex_pkg::CH_SEMI);
                n = $urandom_range(0, 5);
                repeat (n) add_char(mixed_char(1'b1));
            end
        end
        else if (kind < 88)
        begin
            n = $urandom_range(0, 10);
            repeat (n) add_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(0, 14);
            repeat (n) add_char(mixed_char(1'b1));
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (model.decoded_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        model.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic run_phase(input int setting);
        logic [63:0] text;
        logic [3:0]  len;
        int          stop_at;
        text = printable_key();
        case (setting)
            0: len = 4'd3;
            1:
            begin
                text = {64{1'b1}};
                len  = 4'd8;
            end
            2:
            begin
                text = '0;
                len  = 4'd8;
            end
            3: len = 4'd15;
            4: len = 4'd1;
            5:
            begin
                text = {$urandom, $urandom};
                len  = 4'd0;
            end
            6: len = 4'd9;
            default:
            begin
                text = {$urandom, $urandom};
                len  = 4'd5;
            end
        endcase
        wait_idle();
        write_reg(kvhex_pkg::REG_KEY_TEXT, text);
        write_reg(kvhex_pkg::REG_KEY_LENGTH, {60'd0, len});
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
        begin
            compose_line();
            send_line($urandom_range(0, 3) == 0);
        end
    endtask

    // out_ready: bursts of accepts broken by stalls, with occasional long free runs
    initial
    begin
        int run_len;
        int hold;
        out_ready = 1'b0;
        run_len   = 0;
        hold      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready = 1'b0;
                hold--;
            end
            else
            begin
                out_ready = 1'b1;
                if (run_len > 0)
                begin
                    run_len--;
                end
                else
                begin
                    run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                          : $urandom_range(0, 10);
                    hold    = pick_gap();
                end
            end
        end
    end

    initial
    begin
        kvhex_pkg::out_t left;
        int              guard;
        model      = new();
        items_sent = 0;
        lines_sent = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = kvhex_pkg::REG_KEY_TEXT;
        cfg_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key: empty, so '=' alone opens the value
        send_text("=Ff0a;=1");
        send_text("");
        send_text("=");
        send_text("=a");
        send_text("=x0");
        line_buf.delete();
        add_char(kvhex_pkg::CH_EQUALS);
        add_char(8'h00);
        add_char(8'hFF);
        send_line(1'b0);

        for (int s = 0; s < PHASES; s++)
        begin
            run_phase(s);
        end

        @(negedge clk);
        in_valid = 1'b0;
        guard    = 0;
        while (model.decoded_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        while (model.decoded_q.size() != 0)
        begin
            left = model.decoded_q.pop_front();
            model.report($sformatf("missing transfer byte=%02h is_status=%0b code=%0d",
                                   left.out_byte, left.is_status, left.status_code));
        end

        $display("Covered %0d transfers in %0d lines over %0d key settings, %0d data bytes",
                 items_sent, lines_sent, PHASES + 1, model.byte_count);
        $display("Line status: ok %0d, no key %0d, empty %0d, odd %0d, bad digit %0d",
                 model.status_tally[0], model.status_tally[1], model.status_tally[2],
                 model.status_tally[3], model.status_tally[4]);
        if (model.mismatch_count == 0)
        begin
            $display("key_value_hex_field_extractor verification clean");
        end
        else
        begin
            $display("key_value_hex_field_extractor verification failed");
        end
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout: stimulus or results stalled");
        $display("key_value_hex_field_extractor verification failed");
        $finish;
    end

endmodule

/* key_value_hex_field_extractor.f */
hdl/kvhex_pkg.sv
hdl/kvhex_front.sv
hdl/kvhex_queue.sv
hdl/kvhex_back.sv
hdl/key_value_hex_field_extractor.sv
dv/key_value_hex_field_extractor_tb.sv
